[hdl/ffa_pkg.sv]
// shared constants, command codes and status type for the free-list allocator
package ffa_pkg;

  localparam int HEAP_UNITS = 1024;
  localparam int UNIT_BYTES = 16;
  localparam int ADDR_W     = $clog2(HEAP_UNITS);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int BYTES_W    = 15;
  localparam int NEED_W     = BYTES_W - UNIT_SHIFT + 2;

  localparam logic [PTR_W-1:0] PTR_NULL  = PTR_W'(HEAP_UNITS);
  localparam logic [PTR_W-1:0] HEAP_SIZE = PTR_W'(HEAP_UNITS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int CMD_W = 5;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t C_NOP     = 5'd0;
  localparam cmd_t C_INIT    = 5'd1;
  localparam cmd_t C_LOAD    = 5'd2;
  localparam cmd_t C_RD_CUR  = 5'd3;
  localparam cmd_t C_A_SPLIT = 5'd4;
  localparam cmd_t C_A_EXACT = 5'd5;
  localparam cmd_t C_A_NEXT  = 5'd6;
  localparam cmd_t C_A_TAIL  = 5'd7;
  localparam cmd_t C_RD_F    = 5'd8;
  localparam cmd_t C_F_SIZE  = 5'd9;
  localparam cmd_t C_F_STEP  = 5'd10;
  localparam cmd_t C_F_LINK  = 5'd11;
  localparam cmd_t C_F_MNEXT = 5'd12;
  localparam cmd_t C_F_HEAD  = 5'd13;
  localparam cmd_t C_RD_PREV = 5'd14;
  localparam cmd_t C_F_MPREV = 5'd15;
  localparam cmd_t C_F_LPREV = 5'd16;
  localparam cmd_t C_OUT     = 5'd17;

  typedef struct packed {
    logic op;
    logic bytes_zero;
    logic pay_zero;
    logic cur_null;
    logic steps_max;
    logic fits;
    logic exact;
    logic cur_lt_f;
    logic merge_next;
    logic prev_null;
    logic merge_prev;
    logic out_free;
  } status_t;

endpackage

[hdl/ffa_req_if.sv]
// request channel: op, byte count and block address
interface ffa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [ffa_pkg::BYTES_W-1:0]  byte_count;
  logic [ffa_pkg::ADDR_W-1:0]   block_address;

  modport source (output valid, op, byte_count, block_address, input ready);
  modport sink (input valid, op, byte_count, block_address, output ready);
endinterface

[hdl/ffa_rsp_if.sv]
// response channel: status, payload address and free unit count
interface ffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [ffa_pkg::ADDR_W-1:0]  payload_address;
  logic [ffa_pkg::PTR_W-1:0]   units_free;

  modport source (output valid, ok, payload_address, units_free, input ready);
  modport sink (input valid, ok, payload_address, units_free, output ready);
endinterface

[hdl/ffa_dp.sv]
// datapath: header memories, list walk registers and result register
module ffa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ffa_pkg::cmd_t                cmd,
  output ffa_pkg::status_t             status,
  input  logic                         in_op,
  input  logic [ffa_pkg::BYTES_W-1:0]  in_byte_count,
  input  logic [ffa_pkg::ADDR_W-1:0]   in_block_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [ffa_pkg::ADDR_W-1:0]   out_payload_address,
  output logic [ffa_pkg::PTR_W-1:0]    out_units_free
);

  localparam int AW = ffa_pkg::ADDR_W;
  localparam int PW = ffa_pkg::PTR_W;
  localparam int NW = ffa_pkg::NEED_W;
  localparam int BW = ffa_pkg::BYTES_W;

  logic [PW-1:0] size_mem [ffa_pkg::HEAP_UNITS];
  logic [PW-1:0] link_mem [ffa_pkg::HEAP_UNITS];

  logic [PW-1:0] sz, lk;
  logic          op_q, bytes_zero, pay_zero;
  logic [NW-1:0] need;
  logic [AW-1:0] f;
  logic [PW-1:0] cur, prev, steps, head, count, sf, lf;
  logic          res_ok;
  logic [AW-1:0] res_addr;

  logic          rd_en, s_we, l_we;
  logic [AW-1:0] rd_a, s_wa, l_wa;
  logic [PW-1:0] s_wd, l_wd;
  logic [PW-1:0] split, blk_c;
  logic [BW:0]   bytes_rnd;

  assign split     = PW'({2'b0, sz} - need);
  assign blk_c     = cur + split;
  assign bytes_rnd = {1'b0, in_byte_count} + (BW+1)'(ffa_pkg::UNIT_BYTES - 1);

  always_comb begin
    status.op         = op_q;
    status.bytes_zero = bytes_zero;
    status.pay_zero   = pay_zero;
    status.cur_null   = cur[PW-1];
    status.steps_max  = steps[PW-1];
    status.fits       = {2'b0, sz} >= need;
    status.exact      = {2'b0, sz} == need;
    status.cur_lt_f   = cur < {1'b0, f};
    status.merge_next = !cur[PW-1] &&
                        (({2'b0, f} + {1'b0, sf}) == {1'b0, cur});
    status.prev_null  = prev[PW-1];
    status.merge_prev = ({1'b0, prev} + {1'b0, sz}) == {2'b0, f};
    status.out_free   = !out_valid || out_ready;
  end

  // memory port selection per command
  always_comb begin
    rd_en = 1'b0;
    rd_a  = cur[AW-1:0];
    s_we  = 1'b0;
    s_wa  = cur[AW-1:0];
    s_wd  = split;
    l_we  = 1'b0;
    l_wa  = prev[AW-1:0];
    l_wd  = lk;
    case (cmd)
      ffa_pkg::C_INIT: begin
        s_we = 1'b1;
        s_wa = '0;
        s_wd = ffa_pkg::HEAP_SIZE;
        l_we = 1'b1;
        l_wa = '0;
        l_wd = ffa_pkg::PTR_NULL;
      end
      ffa_pkg::C_RD_CUR: rd_en = 1'b1;
      ffa_pkg::C_RD_F: begin
        rd_en = 1'b1;
        rd_a  = f;
      end
      ffa_pkg::C_RD_PREV: begin
        rd_en = 1'b1;
        rd_a  = prev[AW-1:0];
      end
      ffa_pkg::C_A_SPLIT: s_we = 1'b1;
      ffa_pkg::C_A_EXACT: l_we = !prev[PW-1];
      ffa_pkg::C_A_TAIL: begin
        s_we = !blk_c[PW-1];
        s_wa = blk_c[AW-1:0];
        s_wd = need[PW-1:0];
      end
      ffa_pkg::C_F_LINK: begin
        l_we = 1'b1;
        l_wa = f;
        l_wd = cur;
      end
      ffa_pkg::C_F_MNEXT: begin
        s_we = 1'b1;
        s_wa = f;
        s_wd = sf + sz;
        l_we = 1'b1;
        l_wa = f;
        l_wd = lk;
      end
      ffa_pkg::C_F_MPREV: begin
        s_we = 1'b1;
        s_wa = prev[AW-1:0];
        s_wd = sz + sf;
        l_we = 1'b1;
        l_wd = lf;
      end
      ffa_pkg::C_F_LPREV: begin
        l_we = 1'b1;
        l_wd = {1'b0, f};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) size_mem[s_wa] <= s_wd;
    if (l_we) link_mem[l_wa] <= l_wd;
    if (rd_en) begin
      sz <= size_mem[rd_a];
      lk <= link_mem[rd_a];
    end
  end

  // in split, cur and the size read stay put until the tail write
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= ffa_pkg::HEAP_SIZE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd)
        ffa_pkg::C_LOAD: begin
          op_q       <= in_op;
          need       <= NW'(bytes_rnd >> ffa_pkg::UNIT_SHIFT) + NW'(1);
          bytes_zero <= in_byte_count == '0;
          pay_zero   <= in_block_address == '0;
          f          <= in_block_address - AW'(1);
          prev       <= ffa_pkg::PTR_NULL;
          cur        <= head;
          steps      <= '0;
          res_ok     <= 1'b0;
          res_addr   <= '0;
        end
        ffa_pkg::C_A_SPLIT: begin
          count    <= count - need[PW-1:0];
          res_ok   <= 1'b1;
          res_addr <= blk_c[AW-1:0] + AW'(1);
        end
        ffa_pkg::C_A_EXACT: begin
          if (prev[PW-1]) head <= lk;
          count    <= count - need[PW-1:0];
          res_ok   <= 1'b1;
          res_addr <= cur[AW-1:0] + AW'(1);
        end
        ffa_pkg::C_A_NEXT, ffa_pkg::C_F_STEP: begin
          prev  <= cur;
          cur   <= lk;
          steps <= steps + PW'(1);
        end
        ffa_pkg::C_F_SIZE: begin
          sf     <= sz;
          count  <= count + sz;
          res_ok <= 1'b1;
        end
        ffa_pkg::C_F_LINK: lf <= cur;
        ffa_pkg::C_F_MNEXT: begin
          sf <= sf + sz;
          lf <= lk;
        end
        ffa_pkg::C_F_HEAD: head <= {1'b0, f};
        ffa_pkg::C_OUT: begin
          out_valid           <= 1'b1;
          out_ok              <= res_ok;
          out_payload_address <= res_addr;
          out_units_free      <= count;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd == ffa_pkg::C_OUT |=> out_valid)
    else $error("result not presented after load");
  a_rd_cur: assert property (@(posedge clk) disable iff (rst)
    cmd == ffa_pkg::C_RD_CUR |-> !cur[PW-1])
    else $error("read of null current block");
  a_rd_prev: assert property (@(posedge clk) disable iff (rst)
    cmd == ffa_pkg::C_RD_PREV |-> !prev[PW-1])
    else $error("read of null previous block");
  a_split: assert property (@(posedge clk) disable iff (rst)
    cmd == ffa_pkg::C_A_SPLIT |-> ({2'b0, sz} > need))
    else $error("split of a block that does not exceed the request");
`endif

endmodule

[hdl/ffa_ctrl.sv]
// controller: sequences list walks, header updates and result hand-off
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffa_pkg::status_t  status,
  output ffa_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_AEVAL = 4'd4;
  localparam logic [3:0] S_ATAIL = 4'd5;
  localparam logic [3:0] S_RDF   = 4'd6;
  localparam logic [3:0] S_FSZ   = 4'd7;
  localparam logic [3:0] S_FWCHK = 4'd8;
  localparam logic [3:0] S_FSTEP = 4'd9;
  localparam logic [3:0] S_FMN   = 4'd10;
  localparam logic [3:0] S_FPREV = 4'd11;
  localparam logic [3:0] S_FMP   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = ffa_pkg::C_NOP;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd        = ffa_pkg::C_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = ffa_pkg::C_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.op == ffa_pkg::OP_FREE) state_next = status.pay_zero ? S_OUT : S_RDF;
        else state_next = status.bytes_zero ? S_OUT : S_ACHK;
      end
      S_ACHK: begin
        if (status.cur_null || status.steps_max) begin
          state_next = S_OUT;
        end else begin
          cmd        = ffa_pkg::C_RD_CUR;
          state_next = S_AEVAL;
        end
      end
      S_AEVAL: begin
        if (!status.fits) begin
          cmd        = ffa_pkg::C_A_NEXT;
          state_next = S_ACHK;
        end else if (status.exact) begin
          cmd        = ffa_pkg::C_A_EXACT;
          state_next = S_OUT;
        end else begin
          cmd        = ffa_pkg::C_A_SPLIT;
          state_next = S_ATAIL;
        end
      end
      S_ATAIL: begin
        cmd        = ffa_pkg::C_A_TAIL;
        state_next = S_OUT;
      end
      S_RDF: begin
        cmd        = ffa_pkg::C_RD_F;
        state_next = S_FSZ;
      end
      S_FSZ: begin
        cmd        = ffa_pkg::C_F_SIZE;
        state_next = S_FWCHK;
      end
      S_FWCHK: begin
        if (!status.cur_null && status.cur_lt_f && !status.steps_max) begin
          cmd        = ffa_pkg::C_RD_CUR;
          state_next = S_FSTEP;
        end else if (status.merge_next) begin
          cmd        = ffa_pkg::C_RD_CUR;
          state_next = S_FMN;
        end else begin
          cmd        = ffa_pkg::C_F_LINK;
          state_next = S_FPREV;
        end
      end
      S_FSTEP: begin
        cmd        = ffa_pkg::C_F_STEP;
        state_next = S_FWCHK;
      end
      S_FMN: begin
        cmd        = ffa_pkg::C_F_MNEXT;
        state_next = S_FPREV;
      end
      S_FPREV: begin
        if (status.prev_null) begin
          cmd        = ffa_pkg::C_F_HEAD;
          state_next = S_OUT;
        end else begin
          cmd        = ffa_pkg::C_RD_PREV;
          state_next = S_FMP;
        end
      end
      S_FMP: begin
        cmd        = status.merge_prev ? ffa_pkg::C_F_MPREV : ffa_pkg::C_F_LPREV;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd        = ffa_pkg::C_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_init_once: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |=> state == S_IDLE)
    else $error("init did not complete in one cycle");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> cmd == ffa_pkg::C_LOAD || cmd == ffa_pkg::C_NOP)
    else $error("request taken while a command runs");
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_AEVAL |-> $past(cmd) == ffa_pkg::C_RD_CUR)
    else $error("fit check without a header read");
`endif

endmodule

[hdl/first_fit_free_list_allocator_core.sv]
// top level of the first-fit free-list heap allocator
//
// req carries one request per transaction: op 0 allocates byte_count bytes,
// op 1 frees the block whose payload starts at block_address. rsp returns one
// transaction per request: ok, the payload unit address of an allocation,
// and the free unit count after the request.
// Block headers (size and next link) live in two memories with registered
// reads; each list node visited takes a header read and then an evaluation.
// An allocate walks from the head to the first block that fits and takes it
// whole, or takes its tail and writes the tail header, and fails at the end
// of the list; a free walks past the free blocks below the freed one, merges
// with the following block when adjacent and then merges with or links
// the preceding free block; a zero byte count or a zero address is ignored.
// One request is in work at a time; req.ready is high only while idle.
// A result waits in the output register while rsp is stalled, and a new
// request can be accepted meanwhile but completes only once it is taken.
// After rst the S_INIT state writes the single full-heap free block, then
// req.ready rises.
module first_fit_free_list_allocator_core (
  input  logic       clk,
  input  logic       rst,
  ffa_req_if.sink    req,
  ffa_rsp_if.source  rsp
);

  ffa_pkg::cmd_t    cmd;
  ffa_pkg::status_t status;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ffa_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .in_op               (req.op),
    .in_byte_count       (req.byte_count),
    .in_block_address    (req.block_address),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_ok              (rsp.ok),
    .out_payload_address (rsp.payload_address),
    .out_units_free      (rsp.units_free)
  );

endmodule
